### src/amou_pkg.sv
// ----------------------------------------------------------------------------
// amou_pkg
// Shared types and codes of the atomic memory operation unit.
// ----------------------------------------------------------------------------
package amou_pkg;

    // funct5 codes
    localparam logic [4:0] OP_ADD  = 5'h00;
    localparam logic [4:0] OP_SWAP = 5'h01;
    localparam logic [4:0] OP_LR   = 5'h02;
    localparam logic [4:0] OP_SC   = 5'h03;
    localparam logic [4:0] OP_XOR  = 5'h04;
    localparam logic [4:0] OP_OR   = 5'h08;
    localparam logic [4:0] OP_AND  = 5'h0c;
    localparam logic [4:0] OP_MIN  = 5'h10;
    localparam logic [4:0] OP_MAX  = 5'h14;
    localparam logic [4:0] OP_MINU = 5'h18;
    localparam logic [4:0] OP_MAXU = 5'h1c;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAULT = 2'd1;
    localparam logic [1:0] ST_ILLEG = 2'd2;

    // reservation granule limits
    localparam logic [3:0] GRAN_MIN   = 4'd2;
    localparam logic [3:0] GRAN_MAX   = 4'd12;
    localparam logic [3:0] GRAN_RESET = 4'd6;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [31:0] byte_address;
        logic [31:0] operand;
    } t_in_item;

    typedef struct packed {
        logic [31:0] dest_value;
        logic        dest_write;
        logic [1:0]  status;
    } t_out_item;

    // what the back end has to do with a classified item
    typedef enum logic [2:0] {
        K_ILLEGAL = 3'd0,
        K_FAULT   = 3'd1,
        K_SC_FAIL = 3'd2,
        K_SC_OK   = 3'd3,
        K_LR      = 3'd4,
        K_AMO     = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  opcode;
        logic [31:0] byte_address;
        logic [31:0] operand;
    } t_cmd;

endpackage

### src/atomic_memory_op_unit.sv
// ----------------------------------------------------------------------------
// atomic_memory_op_unit
// Word atomics (LR, SC and the AMOs) on an internal memory of MEM_WORDS
// words, one result per item, in order. Items enter through a two-entry
// command queue, so the front keeps taking items while the queue has room,
// also while the back end works or a result waits in the output register.
// With the single memory port, LR and the AMOs read the word in S_IDLE and
// finish in S_EXEC once the output register is free, loading the result and,
// for an AMO only, writing the new value back to the same word. SC, faulting
// and illegal items finish in S_IDLE; no new item is taken in S_EXEC. The
// memory is not cleared at reset: a word must be written before it is read.
// ----------------------------------------------------------------------------
module atomic_memory_op_unit #(
    parameter int MEM_WORDS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  amou_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output amou_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_wdata
);

    amou_pkg::t_cmd front_cmd;
    amou_pkg::t_cmd q_cmd;
    logic           q_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    amou_front #(
        .MEM_WORDS(MEM_WORDS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_q_full   (q_full),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_q_push   (q_push),
        .o_cmd      (front_cmd)
    );

    amou_cmd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (front_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    amou_back #(
        .MEM_WORDS(MEM_WORDS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_cmd    (q_cmd),
        .o_q_pop  (q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

    assign full = q_full;

endmodule

### src/amou_front.sv
// ----------------------------------------------------------------------------
// amou_front
// Accepts items, checks address and opcode, tracks the LR/SC reservation and
// hands a classified command to the command queue.
// ----------------------------------------------------------------------------
module amou_front #(
    parameter int MEM_WORDS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  amou_pkg::t_in_item i_item,
    input  logic              i_q_full,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_wdata,
    output logic              o_q_push,
    output amou_pkg::t_cmd    o_cmd
);

    logic [3:0]  r_gran;
    logic [3:0]  r_held;
    logic        r_res_valid;
    logic [31:0] r_res_base;

    logic [3:0]  n_held;
    logic        n_res_valid;
    logic [31:0] n_res_base;

    logic        accept;
    logic        addr_ok;
    logic        legal;
    logic        in_rsv;
    logic [3:0]  gran_eff;
    logic [31:0] new_lo_mask;
    logic [31:0] held_lo_mask;
    logic [31:0] held_off;

    assign accept = i_push && !i_q_full;

    assign addr_ok = (i_item.byte_address[1:0] == 2'b00) &&
                     ({2'b00, i_item.byte_address[31:2]} < 32'(MEM_WORDS));

    always_comb begin
        unique case (i_item.opcode) inside
            amou_pkg::OP_LR, amou_pkg::OP_ADD, amou_pkg::OP_SWAP, amou_pkg::OP_XOR,
            amou_pkg::OP_OR, amou_pkg::OP_AND, amou_pkg::OP_MIN, amou_pkg::OP_MAX,
            amou_pkg::OP_MINU, amou_pkg::OP_MAXU: legal = 1'b1;
            default: legal = 1'b0;
        endcase
    end

    assign gran_eff = (r_gran < amou_pkg::GRAN_MIN) ? amou_pkg::GRAN_MIN :
                      (r_gran > amou_pkg::GRAN_MAX) ? amou_pkg::GRAN_MAX : r_gran;

    assign new_lo_mask  = (32'd1 << gran_eff) - 32'd1;
    assign held_lo_mask = (32'd1 << r_held) - 32'd1;
    assign held_off     = i_item.byte_address & held_lo_mask;

    // base is granule aligned, so the word must sit fully inside the granule
    assign in_rsv = r_res_valid &&
                    ((i_item.byte_address & ~held_lo_mask) == r_res_base) &&
                    (held_off <= held_lo_mask - 32'd3);

    always_comb begin
        o_cmd.opcode       = i_item.opcode;
        o_cmd.byte_address = i_item.byte_address;
        o_cmd.operand      = i_item.operand;
        n_held      = r_held;
        n_res_valid = r_res_valid;
        n_res_base  = r_res_base;
        if (i_item.opcode == amou_pkg::OP_SC) begin
            n_res_valid = 1'b0;
            if (!in_rsv) begin
                o_cmd.kind = amou_pkg::K_SC_FAIL;
            end else if (!addr_ok) begin
                o_cmd.kind = amou_pkg::K_FAULT;
            end else begin
                o_cmd.kind = amou_pkg::K_SC_OK;
            end
        end else if (!legal) begin
            o_cmd.kind = amou_pkg::K_ILLEGAL;
        end else if (!addr_ok) begin
            o_cmd.kind = amou_pkg::K_FAULT;
        end else if (i_item.opcode == amou_pkg::OP_LR) begin
            o_cmd.kind  = amou_pkg::K_LR;
            n_res_valid = 1'b1;
            n_held      = gran_eff;
            n_res_base  = i_item.byte_address & ~new_lo_mask;
        end else begin
            o_cmd.kind = amou_pkg::K_AMO;
        end
    end

    assign o_q_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gran      <= amou_pkg::GRAN_RESET;
            r_held      <= amou_pkg::GRAN_RESET;
            r_res_valid <= 1'b0;
            r_res_base  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_gran <= i_cfg_wdata;
            end
            if (accept) begin
                r_held      <= n_held;
                r_res_valid <= n_res_valid;
                r_res_base  <= n_res_base;
            end
        end
    end

    a_sc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.opcode == amou_pkg::OP_SC) |=> !r_res_valid)
        else $error("reservation survived an SC");

    a_lr_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (o_cmd.kind == amou_pkg::K_LR) |=> r_res_valid &&
        ((r_res_base & ((32'd1 << r_held) - 32'd1)) == 32'd0))
        else $error("LR left no aligned reservation");

endmodule

### src/amou_cmd_queue.sv
// ----------------------------------------------------------------------------
// amou_cmd_queue
// Two-entry queue of classified commands between front and back end.
// ----------------------------------------------------------------------------
module amou_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  amou_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output amou_pkg::t_cmd o_cmd
);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    amou_pkg::t_cmd   r_ent [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_ent[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(Q_DEPTH))
        else $error("command queue overfilled");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) || (r_count == CNT_W'(Q_DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers out of step with count");

endmodule

### src/amou_back.sv
// ----------------------------------------------------------------------------
// amou_back
// Carries out commands on the word memory (an AMO reads, combines, writes back)
// and places each result in the output register.
// ----------------------------------------------------------------------------
module amou_back #(
    parameter int MEM_WORDS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  amou_pkg::t_cmd      i_cmd,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output amou_pkg::t_out_item o_result
);

    localparam int IDX_W = $clog2(MEM_WORDS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_back_state;

    t_back_state         r_state, n_state;
    amou_pkg::t_cmd      r_cmd;
    logic [31:0]         r_rdata;
    amou_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;
    logic [31:0]         r_mem [MEM_WORDS];

    logic             out_free;
    logic             load;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wdata;
    logic [31:0]      amo_val;
    logic [IDX_W-1:0] head_idx;
    logic [IDX_W-1:0] cur_idx;

    assign out_free = !r_out_valid || i_pop;
    assign head_idx = i_cmd.byte_address[IDX_W+1:2];
    assign cur_idx  = r_cmd.byte_address[IDX_W+1:2];

    always_comb begin
        case (r_cmd.opcode)
            amou_pkg::OP_ADD:  amo_val = r_rdata + r_cmd.operand;
            amou_pkg::OP_XOR:  amo_val = r_rdata ^ r_cmd.operand;
            amou_pkg::OP_OR:   amo_val = r_rdata | r_cmd.operand;
            amou_pkg::OP_AND:  amo_val = r_rdata & r_cmd.operand;
            amou_pkg::OP_MIN:  amo_val = ($signed(r_rdata) < $signed(r_cmd.operand)) ?
                                         r_rdata : r_cmd.operand;
            amou_pkg::OP_MAX:  amo_val = ($signed(r_rdata) > $signed(r_cmd.operand)) ?
                                         r_rdata : r_cmd.operand;
            amou_pkg::OP_MINU: amo_val = (r_rdata < r_cmd.operand) ? r_rdata : r_cmd.operand;
            amou_pkg::OP_MAXU: amo_val = (r_rdata > r_cmd.operand) ? r_rdata : r_cmd.operand;
            default:           amo_val = r_cmd.operand;
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        load    = 1'b0;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        waddr   = head_idx;
        wdata   = i_cmd.operand;
        n_out   = '{dest_value: 32'd0, dest_write: 1'b0, status: amou_pkg::ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_cmd.kind == amou_pkg::K_LR || i_cmd.kind == amou_pkg::K_AMO) begin
                        // read now, finish in S_EXEC once the output register is free
                        o_q_pop = 1'b1;
                        mem_re  = 1'b1;
                        n_state = S_EXEC;
                    end else if (out_free) begin
                        o_q_pop = 1'b1;
                        load    = 1'b1;
                        unique case (i_cmd.kind)
                            amou_pkg::K_ILLEGAL: n_out.status = amou_pkg::ST_ILLEG;
                            amou_pkg::K_FAULT:   n_out.status = amou_pkg::ST_FAULT;
                            amou_pkg::K_SC_FAIL: begin
                                n_out.dest_value = 32'd1;
                                n_out.dest_write = 1'b1;
                            end
                            amou_pkg::K_SC_OK: begin
                                n_out.dest_write = 1'b1;
                                mem_we           = 1'b1;
                            end
                            default: n_out.status = amou_pkg::ST_ILLEG;
                        endcase
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    load             = 1'b1;
                    n_out.dest_value = r_rdata;
                    n_out.dest_write = 1'b1;
                    waddr            = cur_idx;
                    wdata            = amo_val;
                    mem_we           = (r_cmd.kind == amou_pkg::K_AMO);
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[head_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_cmd <= i_cmd;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    a_exec_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (r_cmd.kind == amou_pkg::K_LR ||
                                 r_cmd.kind == amou_pkg::K_AMO))
        else $error("memory pass started for a command that needs none");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> !r_out_valid || i_pop)
        else $error("result overwritten before transfer");

endmodule

### verif/atomic_memory_op_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atomic_memory_op_unit_tb
// Self-checking bench for the word atomic unit. Items go in through the push
// side with random gaps and results come out through the pop side with random
// stalls, each of which some phases turn off. Every transfer on the push side
// is run through a local copy of the memory and the reservation, and each
// popped result is checked field by field against the oldest predicted one.
// Directed tests cover reset behavior, operand extremes of every AMO and the
// reservation rules. Random phases then run under several granule settings.
// ----------------------------------------------------------------------------
module atomic_memory_op_unit_tb;

    localparam int MEM_WORDS     = 1024;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    // funct5 values with no operation behind them
    localparam logic [4:0] OP_UNUSED_LOW = 5'h05;
    localparam logic [4:0] OP_UNUSED_TOP = 5'h1f;

    typedef struct {
        amou_pkg::t_out_item result;
        bit                  value_known;
    } t_awaited;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                push        = 1'b0;
    logic                full;
    amou_pkg::t_in_item  i_item      = '0;
    logic                empty;
    logic                pop         = 1'b0;
    amou_pkg::t_out_item o_result;
    logic                i_cfg_we    = 1'b0;
    logic [3:0]          i_cfg_wdata = '0;

    // local copy of the unit state
    logic [31:0] mem_words [MEM_WORDS];
    bit          word_written [MEM_WORDS];
    int          written_words [$];
    bit          rsv_valid   = 1'b0;
    logic [31:0] rsv_base    = '0;
    int          rsv_log2    = 6;
    logic [3:0]  granule_reg = amou_pkg::GRAN_RESET;

    t_awaited awaited_results [$];
    int       error_count  = 0;
    int       stall_cycles = 0;
    bit       send_idle_on = 1'b1;
    bit       recv_idle_on = 1'b1;

    atomic_memory_op_unit #(
        .MEM_WORDS(MEM_WORDS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit is_atomic_op(input logic [4:0] op);
        case (op) inside
            amou_pkg::OP_ADD, amou_pkg::OP_SWAP, amou_pkg::OP_LR, amou_pkg::OP_SC,
            amou_pkg::OP_XOR, amou_pkg::OP_OR, amou_pkg::OP_AND, amou_pkg::OP_MIN,
            amou_pkg::OP_MAX, amou_pkg::OP_MINU, amou_pkg::OP_MAXU: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // 0..8 are the read-modify-write operations, then LR and SC
    function automatic logic [4:0] atomic_opcode(input int k);
        case (k)
            0: return amou_pkg::OP_SWAP;
            1: return amou_pkg::OP_ADD;
            2: return amou_pkg::OP_XOR;
            3: return amou_pkg::OP_AND;
            4: return amou_pkg::OP_OR;
            5: return amou_pkg::OP_MIN;
            6: return amou_pkg::OP_MAX;
            7: return amou_pkg::OP_MINU;
            8: return amou_pkg::OP_MAXU;
            9: return amou_pkg::OP_LR;
            default: return amou_pkg::OP_SC;
        endcase
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_written();
        return 32'(written_words[$urandom_range(0, written_words.size() - 1)]) << 2;
    endfunction

    function automatic logic [31:0] fault_address();
        logic [31:0] a;
        case ($urandom_range(0, 2))
            0: begin
                a = $urandom_range(0, 4 * MEM_WORDS - 1);
                if (a[1:0] == 2'b00) a[0] = 1'b1;
            end
            1: begin
                a = $urandom & ~32'h3;
                if (a < 4 * MEM_WORDS) a = a | 32'h0000_1000;
            end
            default: begin
                a = $urandom;
                if (a[1:0] == 2'b00 && a < 4 * MEM_WORDS) a[1] = 1'b1;
            end
        endcase
        return a;
    endfunction

    // next state and result of one accepted item
    task automatic apply_atomic(input amou_pkg::t_in_item it, output t_awaited aw);
        logic [31:0] addr;
        logic [31:0] src;
        logic [31:0] old_word;
        logic [31:0] new_word;
        logic [63:0] lo;
        logic [63:0] hi;
        bit          addr_ok;
        bit          in_rsv;
        int          idx;
        int          g;
        addr    = it.byte_address;
        src     = it.operand;
        addr_ok = (addr[1:0] == 2'b00) && ((addr >> 2) < MEM_WORDS);
        idx     = addr_ok ? int'(addr >> 2) : 0;
        aw.result      = '0;
        aw.value_known = 1'b1;
        if (it.opcode == amou_pkg::OP_SC) begin
            // range uses the size captured by the LR, no 32-bit wrap
            lo     = {32'd0, rsv_base};
            hi     = lo + (64'd1 << rsv_log2) - 64'd1;
            in_rsv = rsv_valid && ({32'd0, addr} >= lo) && ({32'd0, addr} + 64'd3 <= hi);
            rsv_valid = 1'b0;
            if (!in_rsv) begin
                aw.result.dest_value = 32'd1;
                aw.result.dest_write = 1'b1;
                aw.result.status     = amou_pkg::ST_OK;
            end else if (!addr_ok) begin
                aw.result.status = amou_pkg::ST_FAULT;
            end else begin
                if (!word_written[idx]) written_words.push_back(idx);
                word_written[idx]    = 1'b1;
                mem_words[idx]       = src;
                aw.result.dest_write = 1'b1;
                aw.result.status     = amou_pkg::ST_OK;
            end
        end else if (!is_atomic_op(it.opcode)) begin
            aw.result.status = amou_pkg::ST_ILLEG;
        end else if (!addr_ok) begin
            aw.result.status = amou_pkg::ST_FAULT;
        end else begin
            old_word             = mem_words[idx];
            aw.value_known       = word_written[idx];
            aw.result.dest_value = old_word;
            aw.result.dest_write = 1'b1;
            aw.result.status     = amou_pkg::ST_OK;
            if (it.opcode == amou_pkg::OP_LR) begin
                g = granule_reg;
                if (g < amou_pkg::GRAN_MIN) g = amou_pkg::GRAN_MIN;
                if (g > amou_pkg::GRAN_MAX) g = amou_pkg::GRAN_MAX;
                rsv_valid = 1'b1;
                rsv_log2  = g;
                rsv_base  = addr & ~((32'd1 << g) - 32'd1);
            end else begin
                case (it.opcode)
                    amou_pkg::OP_ADD:  new_word = old_word + src;
                    amou_pkg::OP_XOR:  new_word = old_word ^ src;
                    amou_pkg::OP_OR:   new_word = old_word | src;
                    amou_pkg::OP_AND:  new_word = old_word & src;
                    amou_pkg::OP_MIN:  new_word = ($signed(old_word) < $signed(src)) ?
                                                  old_word : src;
                    amou_pkg::OP_MAX:  new_word = ($signed(old_word) > $signed(src)) ?
                                                  old_word : src;
                    amou_pkg::OP_MINU: new_word = (old_word < src) ? old_word : src;
                    amou_pkg::OP_MAXU: new_word = (old_word > src) ? old_word : src;
                    default:           new_word = src;
                endcase
                mem_words[idx] = new_word;
            end
        end
    endtask

    // called at a falling edge, returns at a falling edge with push still high
    task automatic send_item(input logic [4:0] op, input logic [31:0] addr,
                             input logic [31:0] operand);
        amou_pkg::t_in_item it;
        t_awaited           aw;
        int                 gap;
        it.opcode       = op;
        it.byte_address = addr;
        it.operand      = operand;
        gap = send_idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do begin
            @(posedge i_clk);
        end while (full);
        apply_atomic(it, aw);
        awaited_results.push_back(aw);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        push <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_granule(input logic [3:0] value);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        granule_reg = value;
    endtask

    // nothing in memory may be read yet
    task automatic test_reset_behavior();
        send_item(amou_pkg::OP_SC, 32'h0000_0000, 32'h1234_5678);
        send_item(amou_pkg::OP_LR, 32'h0000_0002, $urandom);
        send_item(amou_pkg::OP_ADD, 32'h0000_1000, $urandom);
        send_item(amou_pkg::OP_SWAP, 32'hffff_ffff, $urandom);
        send_item(OP_UNUSED_TOP, 32'h0000_0000, $urandom);
    endtask

    task automatic test_preload();
        int idx;
        write_granule(amou_pkg::GRAN_MAX);
        // no word can be written before one has been read: the first LR
        // returns an unknown word, after that the whole-memory reservation
        // lets each SC fill one word
        send_item(amou_pkg::OP_LR, 32'h0000_0000, $urandom);
        send_item(amou_pkg::OP_SC, 32'h0000_0000, 32'hffff_ffff);
        for (int k = 0; k < 47; k++) begin
            if (k < 7) idx = k + 1;
            else if (k < 15) idx = MEM_WORDS - 8 + (k - 7);
            else idx = $urandom_range(8, MEM_WORDS - 9);
            send_item(amou_pkg::OP_LR, pick_written(), rand_operand());
            send_item(amou_pkg::OP_SC, 32'(idx) << 2, rand_operand());
        end
    endtask

    task automatic test_amo_extremes();
        send_item(amou_pkg::OP_SWAP, 32'h0000_0004, 32'hffff_ffff);
        send_item(amou_pkg::OP_ADD,  32'h0000_0004, 32'h0000_0001);
        send_item(amou_pkg::OP_XOR,  32'h0000_0004, 32'ha5a5_a5a5);
        send_item(amou_pkg::OP_OR,   32'h0000_0004, 32'h5a5a_5a5a);
        send_item(amou_pkg::OP_AND,  32'h0000_0004, 32'h0000_ffff);
        send_item(amou_pkg::OP_SWAP, 32'h0000_0004, 32'h8000_0000);
        send_item(amou_pkg::OP_MIN,  32'h0000_0004, 32'h7fff_ffff);
        send_item(amou_pkg::OP_MAX,  32'h0000_0004, 32'h7fff_ffff);
        send_item(amou_pkg::OP_MINU, 32'h0000_0004, 32'h8000_0000);
        send_item(amou_pkg::OP_MAXU, 32'h0000_0004, 32'hffff_ffff);
        send_item(amou_pkg::OP_MIN,  32'h0000_0004, 32'h0000_0000);
        send_item(amou_pkg::OP_MAX,  32'h0000_0ffc, 32'h8000_0000);
        send_item(amou_pkg::OP_MINU, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_UNUSED_LOW, 32'hffff_fffc, 32'hffff_ffff);
    endtask

    task automatic test_reservation_rules();
        write_granule(amou_pkg::GRAN_RESET);
        // unaligned SC inside the granule faults and still drops the reservation
        send_item(amou_pkg::OP_LR, 32'h0000_0004, $urandom);
        send_item(amou_pkg::OP_SC, 32'h0000_0001, $urandom);
        send_item(amou_pkg::OP_SC, 32'h0000_0000, $urandom);
        // AMOs and a faulting LR leave the reservation alone
        send_item(amou_pkg::OP_LR,  32'h0000_0004, $urandom);
        send_item(amou_pkg::OP_ADD, 32'h0000_0008, $urandom);
        send_item(amou_pkg::OP_LR,  32'h0000_0003, $urandom);
        send_item(amou_pkg::OP_SC,  32'h0000_003c, 32'hdead_beef);
        // one byte past the granule, then a second SC with nothing reserved
        send_item(amou_pkg::OP_LR, 32'h0000_0004, $urandom);
        send_item(amou_pkg::OP_SC, 32'h0000_0040, $urandom);
        send_item(amou_pkg::OP_SC, 32'h0000_0004, $urandom);
        write_granule(amou_pkg::GRAN_MIN);
        send_item(amou_pkg::OP_LR, 32'h0000_0008, $urandom);
        send_item(amou_pkg::OP_SC, 32'h0000_000c, $urandom);
        send_item(amou_pkg::OP_LR, 32'h0000_0008, $urandom);
        send_item(amou_pkg::OP_SC, 32'h0000_0008, 32'h0123_4567);
        // register values outside the legal span clamp
        write_granule(4'd0);
        send_item(amou_pkg::OP_LR, 32'h0000_0010, $urandom);
        send_item(amou_pkg::OP_SC, 32'h0000_0014, $urandom);
        write_granule(4'd15);
        send_item(amou_pkg::OP_LR, 32'h0000_0010, $urandom);
        send_item(amou_pkg::OP_SC, 32'h0000_0ffc, 32'h7654_3210);
        // size is the one in force when the LR ran
        write_granule(amou_pkg::GRAN_MAX);
        send_item(amou_pkg::OP_LR, 32'h0000_0000, $urandom);
        write_granule(amou_pkg::GRAN_MIN);
        send_item(amou_pkg::OP_SC, 32'h0000_0800, 32'h0f0f_0f0f);
    endtask

    task automatic run_random(input int item_count);
        int          sent;
        int          pick;
        int          n_amo;
        int          words;
        logic [4:0]  op;
        logic [31:0] sc_addr;
        sent = 0;
        while (sent < item_count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_item(amou_pkg::OP_LR, pick_written(), rand_operand());
                n_amo = $urandom_range(0, 2);
                repeat (n_amo) send_item(atomic_opcode($urandom_range(0, 8)), pick_written(),
                                         rand_operand());
                words = 1 << (rsv_log2 - 2);
                case ($urandom_range(0, 9))
                    7: sc_addr = rsv_base + (32'd1 << rsv_log2);
                    8: sc_addr = rsv_base + 32'($urandom_range(1, 3));
                    9: sc_addr = pick_written();
                    default: sc_addr = rsv_base + 32'($urandom_range(0, words - 1)) * 4;
                endcase
                send_item(amou_pkg::OP_SC, sc_addr, rand_operand());
                sent += 2 + n_amo;
            end else if (pick < 82) begin
                op = ($urandom_range(0, 9) == 0) ? amou_pkg::OP_LR :
                                                   atomic_opcode($urandom_range(0, 8));
                send_item(op, pick_written(), rand_operand());
                sent++;
            end else if (pick < 90) begin
                do begin
                    op = 5'($urandom_range(0, 31));
                end while (is_atomic_op(op));
                send_item(op, $urandom_range(0, 1) ? $urandom : pick_written(), $urandom);
                sent++;
            end else if (pick < 96) begin
                send_item(atomic_opcode($urandom_range(0, 10)), fault_address(), $urandom);
                sent++;
            end else begin
                send_item(amou_pkg::OP_SC, 32'($urandom_range(0, MEM_WORDS - 1)) << 2,
                          rand_operand());
                sent++;
            end
            if ($urandom_range(0, 149) == 0) wait_results_drained();
        end
    endtask

    task automatic test_random_phases();
        logic [3:0] setting;
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: setting = amou_pkg::GRAN_MIN;
                1: setting = 4'd0;
                2: setting = 4'd15;
                3: setting = amou_pkg::GRAN_RESET;
                4: setting = amou_pkg::GRAN_MAX;
                default: setting = 4'($urandom_range(1, 14));
            endcase
            write_granule(setting);
            if (p < 4) begin
                send_idle_on = (p != 1) && (p != 3);
                recv_idle_on = (p != 2) && (p != 3);
            end else begin
                send_idle_on = $urandom_range(0, 3) != 0;
                recv_idle_on = $urandom_range(0, 3) != 0;
            end
            run_random(105);
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_behavior();
        test_preload();
        test_amo_extremes();
        test_reservation_rules();
        test_random_phases();
        wait_results_drained();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // pop side: random stall before each result while recv_idle_on, check on the transfer
    initial begin
        t_awaited aw;
        int       stall;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = recv_idle_on ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (empty);
            if (awaited_results.size() == 0) begin
                $display("%0t: result with nothing awaited: expected none, got %h",
                         $time, o_result);
                error_count++;
            end else begin
                aw = awaited_results.pop_front();
                if (aw.value_known && o_result.dest_value !== aw.result.dest_value) begin
                    $display("%0t: dest_value expected %h, got %h",
                             $time, aw.result.dest_value, o_result.dest_value);
                    error_count++;
                end
                if (o_result.dest_write !== aw.result.dest_write) begin
                    $display("%0t: dest_write expected %b, got %b",
                             $time, aw.result.dest_write, o_result.dest_write);
                    error_count++;
                end
                if (o_result.status !== aw.result.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, aw.result.status, o_result.status);
                    error_count++;
                end
            end
            @(negedge i_clk);
        end
    end

    // stop a hung run: too many cycles without a transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
